/* sv/sabc_pkg.sv */
`default_nettype none
package sabc_pkg;
	localparam int WAYS = 4;
	localparam int SETS = 16;
	localparam int LINE_BYTES = 64;
	localparam int ADDRESS_BITS = 16;
	localparam int WAY_W = $clog2(WAYS);
	localparam int SET_W = $clog2(SETS);
	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int TAG_W = ADDRESS_BITS - SET_W - OFF_W;
	localparam int LINE_W = SET_W + WAY_W;
	localparam int DATA_AW = LINE_W + OFF_W;
	localparam int AGE_W = (WAY_W > 0) ? WAY_W : 1;
	localparam int META_W = TAG_W + 2 + AGE_W;
	localparam int SET_META_W = WAYS * META_W;

	typedef struct packed {
		logic operation;
		logic [15:0] address;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic hit;
		logic [31:0] access_count;
		logic [31:0] miss_count;
	} rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic valid;
		logic dirty;
		logic [AGE_W-1:0] age;
	} meta_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_WB_RD, ST_WB_WR, ST_FILL_RD, ST_FILL_WR,
		ST_DATA, ST_DONE
	} state_t;
endpackage
`default_nettype wire

/* sv/sabc_ram.sv */
`default_nettype none
module sabc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/set_assoc_write_back_byte_cache.sv */
`default_nettype none
// byte cache, 4 ways x 16 sets x 64-byte lines, write-back, write-allocate, lru
// start is taken when busy is low; the item's result appears on rsp with
// done high for exactly one cycle, and busy stays high until then.
// hit: after the accepting edge the item passes through lookup, data
// read-modify and result (done high); busy falls on the return to idle,
// so a new item is taken only once the last one is through. a miss adds a
// line move, byte by byte, through the data and backing memories: the fill,
// preceded by a write-back of the line when the victim is valid and dirty.
// after reset the block runs a clearing pass over all 65536 bytes of the backing
// memory (the cache data, tag and lru stores are cleared in the same pass)
// with busy high; items are accepted only afterwards.
// the receiver cannot stall; results must be taken as they appear.
module set_assoc_write_back_byte_cache (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire sabc_pkg::req_t req,
	output logic busy,
	output logic done,
	output sabc_pkg::rsp_t rsp
);
	localparam int BW = sabc_pkg::ADDRESS_BITS;

	sabc_pkg::state_t state_q, state_d;
	sabc_pkg::req_t req_q;
	logic [BW:0] cnt_q, cnt_d;
	logic [31:0] acc_q, miss_q;
	logic hit_q;
	logic [sabc_pkg::WAY_W-1:0] way_q;
	logic [sabc_pkg::SET_META_W-1:0] meta_q;
	logic [7:0] byte_q;

	// memories
	logic m_we;
	logic [sabc_pkg::SET_W-1:0] m_wa, m_ra;
	logic [sabc_pkg::SET_META_W-1:0] m_wd, m_rd;
	logic d_we;
	logic [sabc_pkg::DATA_AW-1:0] d_wa, d_ra;
	logic [7:0] d_wd, d_rd;
	logic b_we;
	logic [BW-1:0] b_wa, b_ra;
	logic [7:0] b_wd, b_rd;

	sabc_ram #(.WIDTH(sabc_pkg::SET_META_W), .DEPTH(sabc_pkg::SETS)) u_meta (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
	sabc_ram #(.WIDTH(8), .DEPTH(sabc_pkg::SETS * sabc_pkg::WAYS * sabc_pkg::LINE_BYTES))
	u_data (.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
	sabc_ram #(.WIDTH(8), .DEPTH(1 << BW)) u_back (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

	logic [sabc_pkg::TAG_W-1:0] tag;
	logic [sabc_pkg::SET_W-1:0] set_idx;
	logic [sabc_pkg::OFF_W-1:0] off;
	assign tag = req_q.address[BW-1 -: sabc_pkg::TAG_W];
	assign set_idx = req_q.address[sabc_pkg::OFF_W +: sabc_pkg::SET_W];
	assign off = req_q.address[sabc_pkg::OFF_W-1:0];

	sabc_pkg::meta_t mw [sabc_pkg::WAYS];
	sabc_pkg::meta_t mt [sabc_pkg::WAYS];
	logic lk_hit;
	logic [sabc_pkg::WAY_W-1:0] lk_way;
	logic [sabc_pkg::SET_META_W-1:0] touched;
	logic [sabc_pkg::AGE_W-1:0] old_age;

	always_comb begin
		for (int w = 0; w < sabc_pkg::WAYS; w++) begin
			mw[w] = m_rd[w*sabc_pkg::META_W +: sabc_pkg::META_W];
		end
		lk_hit = 1'b0;
		lk_way = '0;
		for (int w = sabc_pkg::WAYS-1; w >= 0; w--) begin
			if (mw[w].valid && mw[w].tag == tag) begin
				lk_hit = 1'b1;
				lk_way = sabc_pkg::WAY_W'(w);
			end
		end
		if (!lk_hit) begin
			lk_way = '0;
			for (int w = 1; w < sabc_pkg::WAYS; w++) begin
				if (mw[w].age > mw[lk_way].age) begin
					lk_way = sabc_pkg::WAY_W'(w);
				end
			end
			for (int w = sabc_pkg::WAYS-1; w >= 0; w--) begin
				if (!mw[w].valid) begin
					lk_way = sabc_pkg::WAY_W'(w);
				end
			end
		end
		// recency update, then install the accessed way
		old_age = mw[lk_way].valid ? mw[lk_way].age : sabc_pkg::AGE_W'(sabc_pkg::WAYS-1);
		for (int w = 0; w < sabc_pkg::WAYS; w++) begin
			mt[w] = mw[w];
			if (sabc_pkg::WAY_W'(w) != lk_way && mw[w].valid && mw[w].age < old_age) begin
				mt[w].age = mw[w].age + 1'b1;
			end
		end
		mt[lk_way].age = '0;
		mt[lk_way].tag = tag;
		mt[lk_way].valid = 1'b1;
		mt[lk_way].dirty = (lk_hit && mw[lk_way].dirty) || req_q.operation;
		for (int w = 0; w < sabc_pkg::WAYS; w++) begin
			touched[w*sabc_pkg::META_W +: sabc_pkg::META_W] = mt[w];
		end
	end

	sabc_pkg::meta_t vic;
	assign vic = meta_q[way_q*sabc_pkg::META_W +: sabc_pkg::META_W];
	logic [sabc_pkg::OFF_W-1:0] cofs;
	assign cofs = cnt_q[sabc_pkg::OFF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sabc_pkg::ST_CLEAR;
			cnt_q <= '0;
			acc_q <= '0;
			miss_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (state_q == sabc_pkg::ST_LOOKUP) begin
				if (acc_q != '1) acc_q <= acc_q + 32'd1;
				if (!lk_hit && miss_q != '1) miss_q <= miss_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= req;
		if (state_q == sabc_pkg::ST_LOOKUP) begin
			hit_q <= lk_hit;
			way_q <= lk_way;
			meta_q <= m_rd;
		end
		// on a miss the requested byte is taken straight off the fill
		if (state_q == sabc_pkg::ST_FILL_WR && cofs == off) begin
			byte_q <= b_rd;
		end else if (state_q == sabc_pkg::ST_DATA && (req_q.operation || hit_q)) begin
			byte_q <= req_q.operation ? req_q.write_data : d_rd;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		m_we = 1'b0; m_wa = set_idx; m_wd = touched; m_ra = set_idx;
		d_we = 1'b0; d_wa = {set_idx, way_q, off}; d_wd = req_q.write_data;
		d_ra = {set_idx, way_q, off};
		b_we = 1'b0; b_wa = '0; b_wd = d_rd; b_ra = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			sabc_pkg::ST_CLEAR: begin
				b_we = 1'b1; b_wa = cnt_q[BW-1:0]; b_wd = '0;
				d_we = 1'b1; d_wa = cnt_q[sabc_pkg::DATA_AW-1:0]; d_wd = '0;
				m_we = 1'b1; m_wa = cnt_q[sabc_pkg::SET_W-1:0]; m_wd = '0;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == (BW+1)'((1 << BW) - 1)) begin
					state_d = sabc_pkg::ST_IDLE;
				end
			end
			sabc_pkg::ST_IDLE: begin
				busy = 1'b0;
				m_ra = req.address[sabc_pkg::OFF_W +: sabc_pkg::SET_W];
				if (start) state_d = sabc_pkg::ST_LOOKUP;
			end
			sabc_pkg::ST_LOOKUP: begin
				m_we = 1'b1;
				d_ra = {set_idx, lk_way, off};
				cnt_d = '0;
				if (lk_hit) state_d = sabc_pkg::ST_DATA;
				else if (mw[lk_way].valid && mw[lk_way].dirty) state_d = sabc_pkg::ST_WB_RD;
				else state_d = sabc_pkg::ST_FILL_RD;
			end
			sabc_pkg::ST_WB_RD: begin
				d_ra = {set_idx, way_q, cofs};
				state_d = sabc_pkg::ST_WB_WR;
			end
			sabc_pkg::ST_WB_WR: begin
				b_we = 1'b1;
				b_wa = {vic.tag, set_idx, cofs};
				cnt_d = cnt_q + 1'b1;
				if (cofs == '1) begin
					cnt_d = '0;
					state_d = sabc_pkg::ST_FILL_RD;
				end else state_d = sabc_pkg::ST_WB_RD;
			end
			sabc_pkg::ST_FILL_RD: begin
				b_ra = {tag, set_idx, cofs};
				state_d = sabc_pkg::ST_FILL_WR;
			end
			sabc_pkg::ST_FILL_WR: begin
				d_we = 1'b1;
				d_wa = {set_idx, way_q, cofs};
				d_wd = b_rd;
				cnt_d = cnt_q + 1'b1;
				if (cofs == '1) state_d = sabc_pkg::ST_DATA;
				else state_d = sabc_pkg::ST_FILL_RD;
			end
			sabc_pkg::ST_DATA: begin
				d_we = req_q.operation;
				state_d = sabc_pkg::ST_DONE;
			end
			sabc_pkg::ST_DONE: begin
				done = 1'b1;
				state_d = sabc_pkg::ST_IDLE;
			end
			default: state_d = sabc_pkg::ST_IDLE;
		endcase
	end

	assign rsp.read_data = byte_q;
	assign rsp.hit = hit_q;
	assign rsp.access_count = acc_q;
	assign rsp.miss_count = miss_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result while idle");
	a_miss_le_acc: assert property (@(posedge clk) disable iff (!arst_n) miss_q <= acc_q)
		else $error("miss count above access count");
	a_start_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == sabc_pkg::ST_LOOKUP)
		else $error("accepted item not looked up");
endmodule
`default_nettype wire

/* dv/tb_set_assoc_write_back_byte_cache.sv */
`timescale 1ns / 1ps
class cache_scoreboard;
	bit [7:0] mem_bytes [0:65535];
	bit [7:0] data_bytes [0:4095];
	bit [5:0] tags [0:63];
	bit valid [0:63];
	bit dirty [0:63];
	bit [1:0] age [0:63];
	bit [31:0] accesses;
	bit [31:0] misses;
	sabc_pkg::rsp_t expected_rsp [$];
	int errors;

	function new();
		foreach (mem_bytes[i]) mem_bytes[i] = 0;
		foreach (data_bytes[i]) data_bytes[i] = 0;
		foreach (tags[i]) begin
			tags[i] = 0;
			valid[i] = 0;
			dirty[i] = 0;
			age[i] = 0;
		end
		accesses = 0;
		misses = 0;
		errors = 0;
	endfunction

	function void touch(int set_idx, int way);
		int b;
		int old_age;
		b = set_idx * 4;
		old_age = valid[b + way] ? age[b + way] : 3;
		for (int w = 0; w < 4; w++)
			if (w != way && valid[b + w] && age[b + w] < old_age)
				age[b + w] = age[b + w] + 1;
		age[b + way] = 0;
	endfunction

	function void note_access(sabc_pkg::req_t r);
		int offset, set_idx, tag, b, way, ln;
		sabc_pkg::rsp_t e;
		offset = r.address[5:0];
		set_idx = r.address[9:6];
		tag = r.address[15:10];
		b = set_idx * 4;
		way = -1;
		if (accesses != 32'hFFFF_FFFF) accesses++;
		for (int w = 0; w < 4; w++)
			if (way < 0 && valid[b + w] && tags[b + w] == tag) way = w;
		e.hit = (way >= 0);
		if (way < 0) begin
			if (misses != 32'hFFFF_FFFF) misses++;
			for (int w = 3; w >= 0; w--)
				if (!valid[b + w]) way = w;
			if (way < 0) begin
				way = 0;
				for (int w = 1; w < 4; w++)
					if (age[b + w] > age[b + way]) way = w;
			end
			ln = b + way;
			if (valid[ln] && dirty[ln])
				for (int i = 0; i < 64; i++)
					mem_bytes[{tags[ln], set_idx[3:0], i[5:0]}] = data_bytes[ln * 64 + i];
			for (int i = 0; i < 64; i++)
				data_bytes[ln * 64 + i] = mem_bytes[{tag[5:0], set_idx[3:0], i[5:0]}];
			touch(set_idx, way);
			tags[ln] = tag;
			valid[ln] = 1;
			dirty[ln] = 0;
		end else
			touch(set_idx, way);
		ln = b + way;
		if (r.operation) begin
			data_bytes[ln * 64 + offset] = r.write_data;
			dirty[ln] = 1;
		end
		e.read_data = data_bytes[ln * 64 + offset];
		e.access_count = accesses;
		e.miss_count = misses;
		expected_rsp.push_back(e);
	endfunction

	function void check_rsp(sabc_pkg::rsp_t got);
		sabc_pkg::rsp_t e;
		if (expected_rsp.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = expected_rsp.pop_front();
		if (got.read_data !== e.read_data) begin
			$display("%0t: read_data expected %h actual %h", $time, e.read_data, got.read_data);
			errors++;
		end
		if (got.hit !== e.hit) begin
			$display("%0t: hit expected %b actual %b", $time, e.hit, got.hit);
			errors++;
		end
		if (got.access_count !== e.access_count) begin
			$display("%0t: access_count expected %0d actual %0d", $time, e.access_count,
				got.access_count);
			errors++;
		end
		if (got.miss_count !== e.miss_count) begin
			$display("%0t: miss_count expected %0d actual %0d", $time, e.miss_count,
				got.miss_count);
			errors++;
		end
	endfunction
endclass

module tb_set_assoc_write_back_byte_cache;
	localparam bit OP_READ = 1'b0;
	localparam bit OP_WRITE = 1'b1;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	sabc_pkg::req_t req = '0;
	logic busy;
	logic done;
	sabc_pkg::rsp_t rsp;
	int send_idle_pct;
	cache_scoreboard lines;

	set_assoc_write_back_byte_cache u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && done) lines.check_rsp(rsp);
	end

	task automatic issue_access(bit op, logic [15:0] addr, logic [7:0] wdata);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		start <= 1;
		req <= '{operation: op, address: addr, write_data: wdata};
		@(posedge clk);
		while (busy) @(posedge clk);
		lines.note_access(req);
		@(negedge clk);
		start <= 0;
	endtask

	// a few hot tags per set so lines get reused, evicted dirty and refetched
	task automatic random_access();
		logic [15:0] addr;
		addr = 16'($urandom);
		if ($urandom_range(99) < 80) addr[15:10] = 6'($urandom_range(5));
		if ($urandom_range(99) < 50) addr[9:6] = 4'($urandom_range(1));
		issue_access(1'($urandom_range(1)), addr, 8'($urandom));
	endtask

	initial begin
		lines = new();
		send_idle_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		// directed: fill a set past its ways, dirty evictions, refetch
		issue_access(OP_READ, 16'h0000, 8'h00);
		issue_access(OP_WRITE, 16'h0000, 8'hFF);
		issue_access(OP_WRITE, 16'h003F, 8'hA5);
		issue_access(OP_WRITE, 16'hFFFF, 8'h5A);
		issue_access(OP_READ, 16'hFFFF, 8'hFF);
		for (int t = 1; t <= 5; t++)
			issue_access(OP_WRITE, {t[5:0], 4'h0, 6'h01}, t[7:0]);
		issue_access(OP_READ, 16'h0000, 8'h00);
		issue_access(OP_READ, 16'h003F, 8'h00);
		issue_access(OP_READ, {6'd1, 4'h0, 6'h01}, 8'h00);
		issue_access(OP_READ, {6'd2, 4'h0, 6'h01}, 8'h00);
		issue_access(OP_WRITE, 16'h5555, 8'h55);
		issue_access(OP_WRITE, 16'hAAAA, 8'hAA);
		issue_access(OP_READ, 16'h5555, 8'h00);
		issue_access(OP_READ, 16'hAAAA, 8'h00);
		send_idle_pct = 26;
		repeat (280) random_access();
		send_idle_pct = 74;
		repeat (280) random_access();
		send_idle_pct = 0;
		repeat (280) random_access();
		while (lines.expected_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (lines.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule

/* set_assoc_write_back_byte_cache.f */
sv/sabc_pkg.sv
sv/sabc_ram.sv
sv/set_assoc_write_back_byte_cache.sv
dv/tb_set_assoc_write_back_byte_cache.sv
